// ===== rtl/accel_tilt_angles_assert.svh =====
// Assertion helpers used by the tilt-angle top level.
`ifndef ACCEL_TILT_ANGLES_ASSERT_SVH
`define ACCEL_TILT_ANGLES_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define ATA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define ATA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ata_pkg.sv =====
package ata_pkg;

  // Widths of the datapath
  localparam int ROOT_BITS = 24;
  localparam int DATA_BITS = 28;
  localparam int ACC_BITS  = 25;
  localparam int TAB_LEN   = 24;

  localparam logic [ACC_BITS-1:0] DEG90_Q16 = 25'd5898240;
  localparam logic [15:0]         DEG90_Q8  = 16'd23040;
  localparam logic [7:0]          FRESH_MASK = 8'h03;

  // Lane codes: which angle a word in the chain belongs to
  localparam logic [1:0] LANE_X = 2'd0;
  localparam logic [1:0] LANE_Y = 2'd1;
  localparam logic [1:0] LANE_Z = 2'd2;

  typedef struct packed {
    logic [7:0]  status_bits;
    logic signed [15:0] acc_x;
    logic signed [15:0] acc_y;
    logic signed [15:0] acc_z;
  } sample_t;

  typedef struct packed {
    logic signed [15:0] angle_x;
    logic signed [15:0] angle_y;
    logic signed [15:0] angle_z;
    logic               sample_fresh;
  } angle_t;

  // Root unit status
  typedef struct packed {
    logic                 done;
    logic [ROOT_BITS-1:0] value;
  } root_t;

  // Word handed from cell to cell
  typedef struct packed {
    logic                        valid;
    logic [1:0]                  lane;
    logic                        num_zero;
    logic                        den_zero;
    logic                        neg;
    logic signed [DATA_BITS-1:0] x;
    logic signed [DATA_BITS-1:0] y;
    logic signed [ACC_BITS-1:0]  acc;
  } cell_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_ROOT,
    ST_FEED,
    ST_WAIT,
    ST_DONE
  } state_t;

  // atan(2^-i) in degrees * 65536
  function automatic logic [ACC_BITS-1:0] atan_tab(input int idx);
    logic [ACC_BITS-1:0] v;
    case (idx)
      0:  v = 25'd2949120;
      1:  v = 25'd1740967;
      2:  v = 25'd919879;
      3:  v = 25'd466945;
      4:  v = 25'd234379;
      5:  v = 25'd117304;
      6:  v = 25'd58666;
      7:  v = 25'd29335;
      8:  v = 25'd14668;
      9:  v = 25'd7334;
      10: v = 25'd3667;
      11: v = 25'd1833;
      12: v = 25'd917;
      13: v = 25'd458;
      14: v = 25'd229;
      15: v = 25'd115;
      16: v = 25'd57;
      17: v = 25'd29;
      18: v = 25'd14;
      19: v = 25'd7;
      20: v = 25'd4;
      21: v = 25'd2;
      22: v = 25'd1;
      default: v = 25'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/ata_sqrt.sv =====
module ata_sqrt (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [15:0] a,
  input  logic signed [15:0] b,
  output ata_pkg::root_t     res
);
  import ata_pkg::*;

  logic signed [31:0]     pa;
  logic signed [31:0]     pb;
  logic [30:0]            sa;
  logic [30:0]            sb;
  logic [31:0]            sum;
  logic [47:0]            n;
  logic [26:0]            r;
  logic [26:0]            r_sh;
  logic [27:0]            diff;
  logic [ROOT_BITS-1:0]   q;
  logic [4:0]             cnt;
  logic                   load;
  logic                   run;
  logic                   done;

  // Square both axes
  assign pa  = a * a;
  assign pb  = b * b;
  assign sum = {1'b0, sa} + {1'b0, sb};

  // One root bit per cycle: bring down two bits, try subtract
  assign r_sh = {r[24:0], n[47:46]};
  assign diff = {1'b0, r_sh} - {2'b00, q, 2'b01};

  always_ff @(posedge clk) begin
    if (start) begin
      sa <= pa[30:0];
      sb <= pb[30:0];
    end
    if (load) begin
      n   <= {sum, 16'h0000};
      r   <= '0;
      q   <= '0;
      cnt <= '0;
    end else if (run) begin
      n   <= {n[45:0], 2'b00};
      cnt <= cnt + 5'd1;
      if (!diff[27]) begin
        r <= diff[26:0];
        q <= {q[ROOT_BITS-2:0], 1'b1};
      end else begin
        r <= r_sh;
        q <= {q[ROOT_BITS-2:0], 1'b0};
      end
    end
  end

  // Sequence: square, load, iterate
  always_ff @(posedge clk) begin
    if (rst) begin
      load <= 1'b0;
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      load <= start;
      done <= 1'b0;
      if (load) begin
        run <= 1'b1;
      end else if (run && cnt == 5'(ROOT_BITS - 1)) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  assign res.done  = done;
  assign res.value = q;

endmodule

// ===== rtl/ata_cell.sv =====
module ata_cell #(
  parameter int IDX = 0
) (
  input  logic           clk,
  input  logic           rst,
  input  ata_pkg::cell_t din,
  output ata_pkg::cell_t dout
);
  import ata_pkg::*;

  logic signed [DATA_BITS-1:0] dx;
  logic signed [DATA_BITS-1:0] dy;
  logic [ACC_BITS-1:0]         ang;

  // Floor shifts of the other coordinate
  assign dx  = din.y >>> IDX;
  assign dy  = din.x >>> IDX;
  assign ang = atan_tab(IDX);

  // Rotate toward the x axis and hand on
  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else begin
      dout.valid <= din.valid;
    end
    dout.lane     <= din.lane;
    dout.num_zero <= din.num_zero;
    dout.den_zero <= din.den_zero;
    dout.neg      <= din.neg;
    if (din.y > 0) begin
      dout.x   <= din.x + dx;
      dout.y   <= din.y - dy;
      dout.acc <= din.acc + $signed(ang);
    end else begin
      dout.x   <= din.x - dx;
      dout.y   <= din.y + dy;
      dout.acc <= din.acc - $signed(ang);
    end
  end

endmodule

// ===== rtl/accel_tilt_angles.sv =====
// Channel | Direction | Handshake                    | Word
// sample  | in        | sample_valid / sample_stall  | ata_pkg::sample_t
// angle   | out       | angle_valid  / angle_stall   | ata_pkg::angle_t
//
// One word is worked on at a time. The time from the accepting edge to the edge
// that raises angle_valid is set by the bit-serial root units (start, load, 24
// root bits) and the CORDIC chain; the next accept can come at the edge after
// that one. The three roots run in parallel; the three angles then follow each
// other through one chain of CORDIC_STEPS cells, one cell per iteration. Reset
// clears the held sample to zero and the control state. A result held under
// angle_stall does not block the next accept; the block only waits at the end if
// the previous result is still not taken.
`include "accel_tilt_angles_assert.svh"

module accel_tilt_angles #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             sample_valid,
  output logic             sample_stall,
  input  ata_pkg::sample_t sample,
  output logic             angle_valid,
  input  logic             angle_stall,
  output ata_pkg::angle_t  angle
);
  import ata_pkg::*;

  state_t              state;
  state_t              state_next;
  logic signed [15:0]  held_x;
  logic signed [15:0]  held_y;
  logic signed [15:0]  held_z;
  logic                fresh;
  logic [1:0]          feed_cnt;
  logic [1:0]          col_cnt;
  logic                sq_start;
  logic                out_load;
  root_t               root_yz;
  root_t               root_xz;
  root_t               root_xy;
  cell_t               chain [CORDIC_STEPS+1];
  cell_t               feed;
  logic [16:0]         mag_x;
  logic [16:0]         mag_y;
  logic [16:0]         mag_z;
  logic [ROOT_BITS-1:0] num;
  logic [ROOT_BITS-1:0] den;
  logic [ACC_BITS-1:0] clamped;
  logic [ACC_BITS-1:0] rounded;
  logic [15:0]         mag_ang;
  logic signed [15:0]  res_ang;
  logic signed [15:0]  res [3];

  // Hold the latest accepted sample whose status bits mark it fresh
  always_ff @(posedge clk) begin
    if (rst) begin
      held_x <= '0;
      held_y <= '0;
      held_z <= '0;
      fresh  <= 1'b0;
    end else if (sample_valid && !sample_stall) begin
      fresh <= (sample.status_bits & FRESH_MASK) != 8'h00;
      if ((sample.status_bits & FRESH_MASK) != 8'h00) begin
        held_x <= sample.acc_x;
        held_y <= sample.acc_y;
        held_z <= sample.acc_z;
      end
    end
  end

  // Root sides
  ata_sqrt u_root_yz (.clk, .rst, .start(sq_start), .a(held_y), .b(held_z), .res(root_yz));
  ata_sqrt u_root_xz (.clk, .rst, .start(sq_start), .a(held_x), .b(held_z), .res(root_xz));
  ata_sqrt u_root_xy (.clk, .rst, .start(sq_start), .a(held_x), .b(held_y), .res(root_xy));

  // Pick the ratio for the lane being fed
  assign mag_x = held_x[15] ? 17'(-$signed({held_x[15], held_x})) : {1'b0, held_x};
  assign mag_y = held_y[15] ? 17'(-$signed({held_y[15], held_y})) : {1'b0, held_y};
  assign mag_z = held_z[15] ? 17'(-$signed({held_z[15], held_z})) : {1'b0, held_z};

  always_comb begin
    case (feed_cnt)
      LANE_X: begin
        num      = {mag_x[15:0], 8'h00};
        den      = root_yz.value;
        feed.neg = held_x[15];
      end
      LANE_Y: begin
        num      = {mag_y[15:0], 8'h00};
        den      = root_xz.value;
        feed.neg = held_y[15];
      end
      default: begin
        num      = root_xy.value;
        den      = {mag_z[15:0], 8'h00};
        feed.neg = held_z[15];
      end
    endcase
    feed.valid    = (state == ST_FEED);
    feed.lane     = feed_cnt;
    feed.num_zero = (num == '0);
    feed.den_zero = (den == '0);
    feed.x        = $signed(DATA_BITS'(den));
    feed.y        = $signed(DATA_BITS'(num));
    feed.acc      = '0;
  end

  // CORDIC chain, one iteration per cell
  assign chain[0] = feed;
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
    ata_cell #(.IDX(i)) u_cell (.clk, .rst, .din(chain[i]), .dout(chain[i+1]));
  end

  // Clamp, round to Q8.8, apply special cases and sign
  always_comb begin
    if (chain[CORDIC_STEPS].acc < 0) begin
      clamped = '0;
    end else if (chain[CORDIC_STEPS].acc > $signed(DEG90_Q16)) begin
      clamped = DEG90_Q16;
    end else begin
      clamped = chain[CORDIC_STEPS].acc;
    end
    rounded = (clamped + ACC_BITS'(128)) >> 8;
    if (chain[CORDIC_STEPS].num_zero) begin
      mag_ang = '0;
    end else if (chain[CORDIC_STEPS].den_zero) begin
      mag_ang = DEG90_Q8;
    end else begin
      mag_ang = rounded[15:0];
    end
    res_ang = chain[CORDIC_STEPS].neg ? -$signed(mag_ang) : $signed(mag_ang);
  end

  // Collect the three angles
  always_ff @(posedge clk) begin
    if (chain[CORDIC_STEPS].valid) begin
      res[chain[CORDIC_STEPS].lane] <= res_ang;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      feed_cnt <= '0;
      col_cnt  <= '0;
    end else begin
      if (state == ST_ROOT) begin
        feed_cnt <= '0;
        col_cnt  <= '0;
      end else begin
        if (state == ST_FEED) begin
          feed_cnt <= feed_cnt + 2'd1;
        end
        if (chain[CORDIC_STEPS].valid) begin
          col_cnt <= col_cnt + 2'd1;
        end
      end
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    sq_start     = 1'b0;
    out_load     = 1'b0;
    sample_stall = (state != ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (sample_valid) begin
          state_next = ST_START;
        end
      end
      ST_START: begin
        sq_start   = 1'b1;
        state_next = ST_ROOT;
      end
      ST_ROOT: begin
        if (root_yz.done) begin
          state_next = ST_FEED;
        end
      end
      ST_FEED: begin
        if (feed_cnt == LANE_Z) begin
          state_next = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (col_cnt == 2'd3) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!angle_valid || !angle_stall) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      angle.angle_x      <= res[LANE_X];
      angle.angle_y      <= res[LANE_Y];
      angle.angle_z      <= res[LANE_Z];
      angle.sample_fresh <= fresh;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_valid <= 1'b0;
    end else if (out_load) begin
      angle_valid <= 1'b1;
    end else if (!angle_stall) begin
      angle_valid <= 1'b0;
    end
  end

  `ATA_ASSERT_IMP(a_roots_together, root_yz.done, root_xz.done && root_xy.done,
                  "root units out of step")
  `ATA_ASSERT_IMP(a_tail_in_window, chain[CORDIC_STEPS].valid,
                  state == ST_FEED || state == ST_WAIT, "chain word outside its window")
  `ATA_ASSERT_NXT(a_accept_starts, sample_valid && !sample_stall, state == ST_START,
                  "accepted word did not start")
  `ATA_ASSERT_NXT(a_load_shows, out_load, angle_valid, "loaded result not shown")

endmodule
